// ===== src/wase_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wase_pkg: shared types, constants and microcode for the speed estimator
// Holds the control word layout, the operation and branch codes, and the
// read-only program that steps the datapath through one angle sample.
// ----------------------------------------------------------------------------
package wase_pkg;

   localparam int ANG_W   = 16;
   localparam int TICK_W  = 32;
   localparam int SPEED_W = 29;
   localparam int ALPHA_W = 16;
   localparam int QUO_W   = 32;
   localparam int STEP_W  = 4;
   localparam int CNT_W   = 5;

   // Number of restoring division iterations, one quotient bit each.
   localparam int DIV_STEPS = QUO_W;

   // 2*pi*1000 in Q16.16.
   localparam logic [28:0] SPEED_K = 29'd411774832;

   localparam logic signed [30:0] SAT_HI = 31'sd268435455;
   localparam logic signed [30:0] SAT_LO = -31'sd268435456;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;

   // Datapath operations.
   localparam logic [3:0] OP_NOP  = 4'd0;
   localparam logic [3:0] OP_LOAD = 4'd1;
   localparam logic [3:0] OP_MUL  = 4'd2;
   localparam logic [3:0] OP_NUM  = 4'd3;
   localparam logic [3:0] OP_DIV  = 4'd4;
   localparam logic [3:0] OP_SIGN = 4'd5;
   localparam logic [3:0] OP_FMUL = 4'd6;
   localparam logic [3:0] OP_FUPD = 4'd7;
   localparam logic [3:0] OP_ARM  = 4'd8;
   localparam logic [3:0] OP_EMIT = 4'd9;

   // Sequencing conditions.
   localparam logic [2:0] COND_NEXT       = 3'd0;
   localparam logic [2:0] COND_WAIT_IN    = 3'd1;
   localparam logic [2:0] COND_IF_UNARMED = 3'd2;
   localparam logic [2:0] COND_IF_DT_ZERO = 3'd3;
   localparam logic [2:0] COND_LOOP       = 3'd4;
   localparam logic [2:0] COND_JUMP       = 3'd5;
   localparam logic [2:0] COND_WAIT_OUT   = 3'd6;

   // Program step addresses.
   localparam logic [STEP_W-1:0] S_IDLE    = 4'd0;
   localparam logic [STEP_W-1:0] S_CHK_ARM = 4'd1;
   localparam logic [STEP_W-1:0] S_CHK_DT  = 4'd2;
   localparam logic [STEP_W-1:0] S_MUL     = 4'd3;
   localparam logic [STEP_W-1:0] S_NUM     = 4'd4;
   localparam logic [STEP_W-1:0] S_DIV     = 4'd5;
   localparam logic [STEP_W-1:0] S_SIGN    = 4'd6;
   localparam logic [STEP_W-1:0] S_FMUL    = 4'd7;
   localparam logic [STEP_W-1:0] S_FUPD    = 4'd8;
   localparam logic [STEP_W-1:0] S_ARM     = 4'd9;
   localparam logic [STEP_W-1:0] S_EMIT    = 4'd10;

   typedef struct packed {
      logic [3:0]        op;
      logic [2:0]        cond;
      logic [STEP_W-1:0] target;
   } ucode_type;

   // Control from sequencer to datapath: the operation and whether it fires.
   typedef struct packed {
      logic [3:0] op;
      logic       go;
   } ctrl_type;

   // Status from datapath back to the sequencer.
   typedef struct packed {
      logic armed;
      logic dt_zero;
      logic out_busy;
   } stat_type;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      unique case (step)
         S_IDLE:    w = '{op: OP_LOAD, cond: COND_WAIT_IN,    target: S_CHK_ARM};
         S_CHK_ARM: w = '{op: OP_NOP,  cond: COND_IF_UNARMED, target: S_ARM};
         S_CHK_DT:  w = '{op: OP_NOP,  cond: COND_IF_DT_ZERO, target: S_EMIT};
         S_MUL:     w = '{op: OP_MUL,  cond: COND_NEXT,       target: S_IDLE};
         S_NUM:     w = '{op: OP_NUM,  cond: COND_NEXT,       target: S_IDLE};
         S_DIV:     w = '{op: OP_DIV,  cond: COND_LOOP,       target: S_IDLE};
         S_SIGN:    w = '{op: OP_SIGN, cond: COND_NEXT,       target: S_IDLE};
         S_FMUL:    w = '{op: OP_FMUL, cond: COND_NEXT,       target: S_IDLE};
         S_FUPD:    w = '{op: OP_FUPD, cond: COND_JUMP,       target: S_EMIT};
         S_ARM:     w = '{op: OP_ARM,  cond: COND_NEXT,       target: S_IDLE};
         S_EMIT:    w = '{op: OP_EMIT, cond: COND_WAIT_OUT,   target: S_IDLE};
         default:   w = '{op: OP_NOP,  cond: COND_JUMP,       target: S_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== src/wase_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wase_seq: microcode sequencer
// Step counter over the program table, an iteration counter for the divide
// loop, and the conditional branch logic that picks the next step.
// ----------------------------------------------------------------------------
module wase_seq
   import wase_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  stat_type stat,
   output ctrl_type ctrl
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   ucode_type         uc;
   logic              go;
   logic              loop_done;

   always_comb begin
      uc        = ucode_rom(step_ff);
      loop_done = (cnt_ff == CNT_W'(DIV_STEPS - 1));
      unique case (uc.cond)
         COND_WAIT_IN:  go = req_valid;
         COND_WAIT_OUT: go = !stat.out_busy;
         default:       go = 1'b1;
      endcase
      ctrl.op = uc.op;
      ctrl.go = go;
   end

   always_comb begin
      step_in = step_ff;
      cnt_in  = cnt_ff;
      unique case (uc.cond)
         COND_NEXT:       step_in = step_ff + 1'b1;
         COND_WAIT_IN,
         COND_WAIT_OUT:   step_in = go ? uc.target : step_ff;
         COND_IF_UNARMED: step_in = stat.armed ? step_ff + 1'b1 : uc.target;
         COND_IF_DT_ZERO: step_in = stat.dt_zero ? uc.target : step_ff + 1'b1;
         COND_LOOP: begin
            if (loop_done) begin
               step_in = step_ff + 1'b1;
               cnt_in  = '0;
            end else begin
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         COND_JUMP:       step_in = uc.target;
         default:         step_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
         cnt_ff  <= '0;
      end else begin
         step_ff <= step_in;
         cnt_ff  <= cnt_in;
      end
   end

   // The iteration counter only runs inside the divide loop.
   a_cnt_in_div: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 |-> step_ff == S_DIV)
      else $error("divide counter active outside the divide step");

   // An accepted word always moves on to the arming check.
   a_load_next: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_LOAD && ctrl.go) |=> step_ff == S_CHK_ARM)
      else $error("sequencer did not advance after accepting a word");

endmodule

// ===== src/wase_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wase_dp: estimator datapath
// Sample registers, angle step and elapsed time, one multiplier stage for
// the scale, a radix-2 restoring divider, the low-pass update with
// saturation, and the result register.
// ----------------------------------------------------------------------------
module wase_dp
   import wase_pkg::*;
#(
   parameter int ANGLE_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_type            ctrl,
   input  logic [ANG_W-1:0]    req_angle,
   input  logic [TICK_W-1:0]   req_tick,
   input  logic                csr_valid,
   input  logic [ALPHA_W-1:0]  csr_data,
   input  logic                rsp_ready,
   output stat_type            stat,
   output logic                rsp_valid,
   output logic [SPEED_W-1:0]  rsp_speed,
   output logic [ANG_W-1:0]    rsp_angle
);

   localparam int AW  = ANGLE_BITS;
   localparam int MW  = AW + 29;
   localparam int NW  = AW + 32;
   localparam int FPW = 47;

   logic [ALPHA_W-1:0]        alpha_ff, alpha_in;
   logic                      armed_ff, armed_in;
   logic [AW-1:0]             last_angle_ff, last_angle_in;
   logic [TICK_W-1:0]         last_tick_ff, last_tick_in;
   logic [ANG_W-1:0]          angle_ff, angle_in;
   logic [TICK_W-1:0]         dt_ff, dt_in;
   logic                      neg_ff, neg_in;
   logic [AW-1:0]             mag_ff, mag_in;
   logic [MW-1:0]             mprod_ff, mprod_in;
   logic [QUO_W-1:0]          quo_ff, quo_in;
   logic [QUO_W-1:0]          rem_ff, rem_in;
   logic signed [29:0]        fdiff_ff, fdiff_in;
   logic signed [FPW-1:0]     fprod_ff, fprod_in;
   logic signed [SPEED_W-1:0] filt_ff, filt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SPEED_W-1:0]        rsp_speed_ff, rsp_speed_in;
   logic [ANG_W-1:0]          rsp_angle_ff, rsp_angle_in;

   logic [AW-1:0]             angle_aw;
   logic [AW-1:0]             diff;
   logic [NW-1:0]             numer;
   logic [QUO_W:0]            shifted;
   logic [QUO_W:0]            trial;
   logic [SPEED_W-1:0]        qmag;
   logic signed [SPEED_W-1:0] raw;
   logic signed [16:0]        alpha_s;
   logic signed [FPW-1:0]     rnd;
   logic signed [30:0]        upd;

   always_comb begin
      alpha_in      = alpha_ff;
      armed_in      = armed_ff;
      last_angle_in = last_angle_ff;
      last_tick_in  = last_tick_ff;
      angle_in      = angle_ff;
      dt_in         = dt_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      mprod_in      = mprod_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      fdiff_in      = fdiff_ff;
      fprod_in      = fprod_ff;
      filt_in       = filt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_speed_in  = rsp_speed_ff;
      rsp_angle_in  = rsp_angle_ff;

      angle_aw = AW'(req_angle);
      diff     = angle_aw - last_angle_ff;
      numer    = NW'(mprod_ff) + (NW'(dt_ff) << (AW - 1));
      shifted  = {rem_ff, quo_ff[QUO_W-1]};
      trial    = shifted - {1'b0, dt_ff};
      qmag     = {1'b0, quo_ff[SPEED_W-2:0]};
      raw      = neg_ff ? $signed(SPEED_W'(0) - qmag) : $signed(qmag);
      alpha_s  = $signed({1'b0, alpha_ff});
      rnd      = fprod_ff + FPW'(32768);
      upd      = $signed({{2{filt_ff[SPEED_W-1]}}, filt_ff}) + $signed(rnd[FPW-1:16]);

      if (csr_valid) begin
         alpha_in = csr_data;
      end

      if (ctrl.go) begin
         unique case (ctrl.op)
            OP_LOAD: begin
               angle_in      = req_angle;
               dt_in         = req_tick - last_tick_ff;
               neg_in        = diff[AW-1];
               mag_in        = diff[AW-1] ? (AW'(0) - diff) : diff;
               last_angle_in = angle_aw;
               last_tick_in  = req_tick;
            end
            OP_MUL: begin
               mprod_in = MW'(mag_ff) * MW'(SPEED_K);
            end
            OP_NUM: begin
               quo_in = numer[NW-1:AW];
               rem_in = '0;
            end
            OP_DIV: begin
               if (!trial[QUO_W]) begin
                  rem_in = trial[QUO_W-1:0];
                  quo_in = {quo_ff[QUO_W-2:0], 1'b1};
               end else begin
                  rem_in = shifted[QUO_W-1:0];
                  quo_in = {quo_ff[QUO_W-2:0], 1'b0};
               end
            end
            OP_SIGN: begin
               fdiff_in = {raw[SPEED_W-1], raw} - {filt_ff[SPEED_W-1], filt_ff};
            end
            OP_FMUL: begin
               fprod_in = FPW'(alpha_s) * FPW'(fdiff_ff);
            end
            OP_FUPD: begin
               if (upd > SAT_HI) begin
                  filt_in = SAT_HI[SPEED_W-1:0];
               end else if (upd < SAT_LO) begin
                  filt_in = SAT_LO[SPEED_W-1:0];
               end else begin
                  filt_in = upd[SPEED_W-1:0];
               end
            end
            OP_ARM: begin
               filt_in  = '0;
               armed_in = 1'b1;
            end
            OP_EMIT: begin
               rsp_valid_in = 1'b1;
               rsp_speed_in = filt_ff;
               rsp_angle_in = angle_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff      <= ALPHA_RESET;
         armed_ff      <= 1'b0;
         last_angle_ff <= '0;
         last_tick_ff  <= '0;
         filt_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         alpha_ff      <= alpha_in;
         armed_ff      <= armed_in;
         last_angle_ff <= last_angle_in;
         last_tick_ff  <= last_tick_in;
         filt_ff       <= filt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff     <= angle_in;
      dt_ff        <= dt_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      mprod_ff     <= mprod_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      fdiff_ff     <= fdiff_in;
      fprod_ff     <= fprod_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_angle_ff <= rsp_angle_in;
   end

   assign stat.armed    = armed_ff;
   assign stat.dt_zero  = (dt_ff == '0);
   assign stat.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_speed     = rsp_speed_ff;
   assign rsp_angle     = rsp_angle_ff;

   // The divider never runs with a zero divisor.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (ctrl.go && ctrl.op == OP_DIV) |-> dt_ff != '0)
      else $error("divide step entered with zero elapsed time");

   // Once armed, the block stays armed until reset.
   a_armed_sticky: assert property (@(posedge clock) disable iff (reset)
      armed_ff |=> armed_ff)
      else $error("armed flag dropped without reset");

endmodule

// ===== src/wrapped_angle_speed_estimator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrapped_angle_speed_estimator_top: angular speed from timestamped angles
// Turns absolute angle samples with millisecond timestamps into a low-pass
// filtered angular speed in rad/s, signed Q13.16, and echoes the angle.
// ----------------------------------------------------------------------------
// Each input word carries an angle (2^ANGLE_BITS counts per turn, upper bits
// ignored for the speed) and a millisecond tick. The first word after reset
// arms the block and returns speed 0. Each later word takes the angle step,
// wrapped to a signed half turn, divides it by the elapsed ticks (modulo
// 2^32) with rounding of halves away from zero, and moves the filtered speed
// toward that raw speed by the weight filter_alpha/65536, saturating to 29
// bits. A word with zero elapsed time leaves the filtered speed unchanged.
// Exactly one result word leaves per input word. A small microcoded
// sequencer drives the datapath; a word that needs the division passes
// through the arming and elapsed-time checks, the scale multiply, the
// numerator step, the 32 iterations of the one-bit-per-cycle restoring
// divider, the sign step, the filter multiply and update and the emit step,
// and the next word is taken only after the emit step. The arming word goes
// from the arming check through the arm step to the emit step, and a
// zero-elapsed word goes from the elapsed-time check straight to the emit
// step. The result sits in an output register, so the next word can be taken
// while a result waits. Neither the input nor the configuration port is ready
// while reset is held. Write filter_alpha only while the block is idle; it resets to 6554 (about 0.1).
// ----------------------------------------------------------------------------
module wrapped_angle_speed_estimator_top
   import wase_pkg::*;
#(
   parameter int ANGLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,    // [15:0] angle_turn, [47:16] tick_ms
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // [28:0] speed_q16, [44:29] angle_out, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data      // filter_alpha
);

   ctrl_type           ctrl;
   stat_type           stat;
   logic [SPEED_W-1:0] rsp_speed;
   logic [ANG_W-1:0]   rsp_angle;

   wase_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   wase_dp #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_angle (req_tdata[15:0]),
      .req_tick  (req_tdata[47:16]),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_ready (rsp_tready),
      .stat      (stat),
      .rsp_valid (rsp_tvalid),
      .rsp_speed (rsp_speed),
      .rsp_angle (rsp_angle)
   );

   // The block takes a word only while the program sits at its load step.
   assign req_tready = (ctrl.op == OP_LOAD) && !reset;
   // The alpha register can be written at any time outside reset.
   assign csr_ready  = !reset;
   assign rsp_tdata  = {3'b000, rsp_angle, rsp_speed};

endmodule

// ===== tb/wrapped_angle_speed_estimator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrapped_angle_speed_estimator_top_tb: self-checking bench for the estimator
// Feeds timestamped angle words through the request stream, predicts the
// filtered speed of each one in the bench, and compares every result word,
// field by field, under random idling, a long result hold-off and several
// settings of the filter weight.
// ----------------------------------------------------------------------------
module wrapped_angle_speed_estimator_top_tb;

   // 2*pi*1000 rad/s per turn per ms, in Q16.16.
   localparam longint unsigned SPEED_SCALE = 64'd411774832;
   localparam longint SPEED_HI = 64'sd268435455;
   localparam longint SPEED_LO = -64'sd268435456;
   localparam logic [15:0] ALPHA_AT_RESET = 16'd6554;
   localparam logic [15:0] HALF_TURN = 16'h8000;
   localparam logic [15:0] MAX_STEP = 16'h7FFF;

   // Covers a whole division word with margin.
   localparam int SETTLE_CYCLES = 60;
   // Cycles without any accepted word before the run is called hung.
   localparam int STALL_LIMIT = 4000;
   localparam int LONG_HOLD = 400;
   localparam int SHOWN_ERRORS = 10;

   typedef struct {
      logic [15:0] angle;
      logic [31:0] tick;
   } angle_sample_type;

   typedef struct {
      logic [28:0] speed;
      logic [15:0] angle;
   } speed_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;    // [15:0] angle_turn, [47:16] tick_ms
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [28:0] speed_q16, [44:29] angle_out, zero pad
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;    // filter_alpha

   wrapped_angle_speed_estimator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Samples waiting to be sent, and the result words still owed by the block.
   angle_sample_type sample_queue[$];
   speed_word_type   speed_expect[$];

   // The bench's own copy of the estimator state and of the filter weight.
   logic [15:0] est_alpha = ALPHA_AT_RESET;
   logic [15:0] est_last_angle = '0;
   logic [31:0] est_last_tick = '0;
   longint      est_speed = 0;
   logic        est_armed = 1'b0;

   // Where the stimulus generator left the angle and the tick.
   logic [15:0] gen_angle = '0;
   logic [31:0] gen_tick = '0;

   // Idling controls, set per phase by the stimulus process.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request = 0;

   int error_count = 0;
   int quiet_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Works out the result word for one accepted sample and advances the
   // predicted state. The first sample only arms; a zero elapsed time keeps
   // the filtered speed; otherwise the wrapped angle step is divided by the
   // elapsed ticks with halves rounded away from zero, and the filter moves
   // toward that raw speed by alpha/65536 with rounding to nearest, halves up.
   function automatic speed_word_type predict_speed(angle_sample_type s);
      speed_word_type w;
      logic [15:0] step;
      logic [31:0] elapsed;
      int step_signed;
      longint unsigned step_mag;
      longint unsigned span;
      longint unsigned quo;
      longint raw;
      longint prod;
      longint next_speed;
      if (!est_armed) begin
         est_armed = 1'b1;
         est_speed = 0;
      end else begin
         elapsed = s.tick - est_last_tick;
         if (elapsed != 32'd0) begin
            step = s.angle - est_last_angle;
            step_signed = $signed(step);
            step_mag = longint'(step_signed < 0 ? -step_signed : step_signed);
            step_mag = step_mag * SPEED_SCALE;
            span = {32'd0, elapsed} << 16;
            quo = (step_mag + (span >> 1)) / span;
            raw = (step_signed < 0) ? -longint'(quo) : longint'(quo);
            prod = longint'({48'd0, est_alpha}) * (raw - est_speed);
            next_speed = est_speed + ((prod + 64'sd32768) >>> 16);
            if (next_speed > SPEED_HI)
               next_speed = SPEED_HI;
            if (next_speed < SPEED_LO)
               next_speed = SPEED_LO;
            est_speed = next_speed;
         end
      end
      est_last_angle = s.angle;
      est_last_tick = s.tick;
      w.speed = est_speed[28:0];
      w.angle = s.angle;
      return w;
   endfunction

   // Sender: offers the head of the sample queue, holds it until it is taken,
   // and now and then inserts an idle burst of random length.
   always @(posedge clock) begin : sender
      int send_gap;
      angle_sample_type taken;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            taken = sample_queue.pop_front();
            speed_expect.push_back(predict_speed(taken));
         end
         if (req_tvalid && !req_tready) begin
            // The offered word stays on the bus until it is accepted.
         end else if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (sample_queue.size() > 0 &&
                      $urandom_range(0, 99) < send_idle_pct) begin
            send_gap = $urandom_range(0, 15);
            req_tvalid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= {sample_queue[0].tick, sample_queue[0].angle};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: checks every accepted result word against the oldest
   // expectation. Its ready follows random bursts, plus one long hold-off
   // when the stimulus process asks for it, counted here.
   always @(posedge clock) begin : receiver
      int recv_gap;
      int hold_left;
      speed_word_type want;
      logic [28:0] got_speed;
      logic [15:0] got_angle;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap = 0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_speed = rsp_tdata[28:0];
            got_angle = rsp_tdata[44:29];
            if (speed_expect.size() == 0) begin
               error_count++;
               if (error_count <= SHOWN_ERRORS)
                  $display("unexpected result word: speed %0d angle 0x%04h",
                           $signed(got_speed), got_angle);
            end else begin
               want = speed_expect.pop_front();
               if (got_speed !== want.speed || got_angle !== want.angle) begin
                  error_count++;
                  if (error_count <= SHOWN_ERRORS)
                     $display("result mismatch: speed %0d angle 0x%04h, expected %0d 0x%04h",
                              $signed(got_speed), got_angle,
                              $signed(want.speed), want.angle);
               end
            end
         end
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < recv_idle_pct) begin
            recv_gap = $urandom_range(0, 15);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: any accepted word on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("wrapped_angle_speed_estimator_top_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_sample(input logic [15:0] angle, input logic [31:0] tick);
      angle_sample_type s;
      s.angle = angle;
      s.tick = tick;
      sample_queue.push_back(s);
      gen_angle = angle;
      gen_tick = tick;
   endtask

   // Mostly plausible encoder traffic: small steps over a few ms. The rest
   // covers zero elapsed time, arbitrary jumps, huge gaps and half turns.
   task automatic add_random_samples(input int count);
      int pick;
      logic [15:0] angle;
      logic [31:0] elapsed;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            elapsed = $urandom_range(1, 10);
            angle = gen_angle + 16'($urandom_range(0, 4000)) - 16'd2000;
         end else if (pick < 65) begin
            elapsed = 32'd0;
            angle = 16'($urandom);
         end else if (pick < 75) begin
            elapsed = $urandom;
            angle = 16'($urandom);
         end else if (pick < 90) begin
            elapsed = $urandom_range(1, 3);
            angle = 16'($urandom);
         end else if (pick < 95) begin
            elapsed = 32'd1;
            angle = gen_angle + (pick[0] ? HALF_TURN : MAX_STEP);
         end else begin
            elapsed = $urandom_range(11, 5000);
            angle = gen_angle + 16'($urandom_range(0, 255));
         end
         add_sample(angle, gen_tick + elapsed);
      end
   endtask

   // Waits until every queued sample is sent and every result has come back,
   // then lets the block settle.
   task automatic wait_drained();
      while (sample_queue.size() != 0 || speed_expect.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes the filter weight while the block is idle.
   task automatic write_alpha(input logic [15:0] value);
      wait_drained();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      est_alpha = value;
      @(negedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset weight. The first word arms the block and
      // the second repeats its tick, so the speed must stay at zero.
      send_idle_pct = 10;
      recv_idle_pct = 10;
      add_sample(16'h1234, 32'd1000);
      add_sample(16'h1234, 32'd1000);
      add_sample(16'h1334, 32'd1001);
      add_sample(16'h9334, 32'd1002);       // exact half turn reads as negative
      add_sample(16'h1333, 32'd1003);       // largest positive step
      add_sample(16'hFFFF, 32'd1003);       // angle moves, time does not
      add_sample(16'h0000, 32'd1004);       // one count forward across zero
      add_sample(16'hFFFF, 32'd1005);       // one count back across zero
      add_sample(16'h07FF, 32'd1006);       // 2048 counts in 1 ms: exact half
      add_sample(16'hFFFF, 32'd1007);       // and the same step backwards
      add_sample(16'hFFFF, 32'hFFFF_FFFE);  // very long gap
      add_sample(16'h0010, 32'h0000_0003);  // tick wraps past 2^32
      add_sample(16'h8010, 32'h0000_0002);  // elapsed time 2^32 - 1
      add_sample(16'h0000, 32'h0000_0000);
      add_sample(16'hFFFF, 32'hFFFF_FFFF);
      add_sample(16'h5555, 32'hAAAA_AAAA);
      add_sample(16'hAAAA, 32'h5555_5555);

      // Full weight: the filtered speed follows the raw speed almost exactly.
      write_alpha(16'hFFFF);
      add_sample(gen_angle + 16'd100, gen_tick + 32'd1);
      add_sample(gen_angle + HALF_TURN, gen_tick + 32'd1);
      add_sample(gen_angle + MAX_STEP, gen_tick + 32'd1);
      add_random_samples(150);

      // Zero weight freezes the filter wherever it stood.
      write_alpha(16'h0000);
      add_sample(gen_angle + 16'd5000, gen_tick + 32'd1);
      add_random_samples(100);

      write_alpha(16'h0001);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_samples(100);

      // Hold off the results for a long stretch while the sender keeps
      // offering, so the output register fills and the input stalls.
      write_alpha(16'($urandom));
      send_idle_pct = 5;
      recv_idle_pct = 20;
      hold_request = LONG_HOLD;
      add_random_samples(300);

      repeat (3) begin
         write_alpha(16'($urandom));
         send_idle_pct = $urandom_range(0, 30);
         recv_idle_pct = $urandom_range(0, 30);
         add_random_samples(100);
         // The sender pauses here until every result has come back.
         wait_drained();
         add_random_samples(100);
      end

      // Last stretch without idling on either side.
      write_alpha(16'h8000);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_samples(200);

      wait_drained();
      if (error_count == 0 && speed_expect.size() == 0) begin
         $display("wrapped_angle_speed_estimator_top_tb: clean");
      end else begin
         $display("wrapped_angle_speed_estimator_top_tb: errors");
      end
      $finish;
   end

endmodule

// ===== wrapped_angle_speed_estimator_top.f =====
src/wase_pkg.sv
src/wase_seq.sv
src/wase_dp.sv
src/wrapped_angle_speed_estimator_top.sv
tb/wrapped_angle_speed_estimator_top_tb.sv
